/* src/rtp_traffic_loss_monitor_assert.svh */
// Assertion macros for the RTP traffic loss monitor RTL.
`ifndef RTP_TRAFFIC_LOSS_MONITOR_ASSERT_SVH
`define RTP_TRAFFIC_LOSS_MONITOR_ASSERT_SVH

// Same-cycle implication, reset masked.
`define RTLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define RTLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rtlm_pkg.sv */
// Types and constants of the RTP traffic loss monitor.
`default_nettype none

package rtlm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_KIND       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_FILTER        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PAYLOAD_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SRC_ADDR     = 3'd4;

    localparam logic [3:0] FK_IP_PKTS      = 4'd0;
    localparam logic [3:0] FK_IP_SRC_PKTS  = 4'd1;
    localparam logic [3:0] FK_IP_BYTES     = 4'd2;
    localparam logic [3:0] FK_TCP_PKTS     = 4'd3;
    localparam logic [3:0] FK_TCP_BYTES    = 4'd4;
    localparam logic [3:0] FK_UDP_PKTS     = 4'd5;
    localparam logic [3:0] FK_UDP_BYTES    = 4'd6;
    localparam logic [3:0] FK_RTP_PKTS     = 4'd7;
    localparam logic [3:0] FK_RTP_BYTES    = 4'd8;
    localparam logic [3:0] FK_LOST_PKTS    = 4'd9;
    localparam logic [3:0] FK_LOST_FRAMES  = 4'd10;

    localparam logic [1:0] PF_NONE     = 2'd0;
    localparam logic [1:0] PF_SRC_PORT = 2'd1;
    localparam logic [1:0] PF_DST_PORT = 2'd2;

    typedef struct packed {
        logic        is_ip;
        logic        is_tcp;
        logic        is_udp;
        logic [31:0] src_addr;
        logic [15:0] ip_total_len;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [6:0]  rtp_type;
        logic [15:0] rtp_seq;
        logic [31:0] rtp_stamp;
    } t_pkt;

    typedef struct packed {
        logic [15:0] feature_value;
    } t_feat;

endpackage

`default_nettype wire

/* src/rtlm_if.sv */
// Valid/ready channel interfaces for packet requests and feature results.
`default_nettype none

interface rtlm_pkt_if;
    import rtlm_pkg::*;
    logic valid;
    logic ready;
    t_pkt data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rtlm_feat_if;
    import rtlm_pkg::*;
    logic  valid;
    logic  ready;
    t_feat data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rtp_traffic_loss_monitor.sv */
// Top level: per-packet feature evaluator with RTP sequence loss tracking.
// Takes packet requests and returns exactly one 16-bit feature value per request, in
// order: a request is held in the input register, then the filter, the 16-bit sequence
// compare and the state update go through one level of logic into the result register.
// Throughput is one request per cycle while the result side takes results; a stalled
// result holds the pipeline without loss. Configuration registers are to be written
// through the plain write port while idle by the user; the block does not enforce it.
`default_nettype none

module rtp_traffic_loss_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rtlm_pkt_if.sink                          i_pkt,
    rtlm_feat_if.source                       o_feat,
    input  logic                              i_cfg_we,
    input  logic [rtlm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rtlm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rtlm_pkg::*;

    `include "rtp_traffic_loss_monitor_assert.svh"

    logic [3:0]  r_feature_kind;
    logic [1:0]  r_port_filter;
    logic [15:0] r_match_port;
    logic [6:0]  r_match_payload_type;
    logic [31:0] r_match_src_addr;

    logic        r_in_valid;
    t_pkt        r_in;
    logic        r_out_valid;
    logic [15:0] r_out_value;

    logic [15:0] r_last_seq;
    logic        r_seq_primed;
    logic [31:0] r_last_stamp;

    logic [15:0] n_last_seq;
    logic        n_seq_primed;
    logic [31:0] n_last_stamp;
    logic [15:0] n_out_value;

    logic        adv;
    logic        proc;
    logic        port_ok;
    logic        rtp_ok;
    logic [15:0] seq_diff;
    logic        newer;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_kind       <= '0;
            r_port_filter        <= '0;
            r_match_port         <= '0;
            r_match_payload_type <= '0;
            r_match_src_addr     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEATURE_KIND:       r_feature_kind       <= i_cfg_data[3:0];
                CFG_PORT_FILTER:        r_port_filter        <= i_cfg_data[1:0];
                CFG_MATCH_PORT:         r_match_port         <= i_cfg_data[15:0];
                CFG_MATCH_PAYLOAD_TYPE: r_match_payload_type <= i_cfg_data[6:0];
                CFG_MATCH_SRC_ADDR:     r_match_src_addr     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign adv         = !r_out_valid || o_feat.ready;
    assign proc        = r_in_valid && adv;
    assign i_pkt.ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_in <= i_pkt.data;
        end
    end

    always_comb begin
        case (r_port_filter)
            PF_SRC_PORT: port_ok = (r_in.src_port == r_match_port);
            PF_DST_PORT: port_ok = (r_in.dst_port == r_match_port);
            default:     port_ok = 1'b1;
        endcase
    end

    assign rtp_ok   = (r_in.is_tcp || r_in.is_udp) && port_ok &&
                      (r_in.rtp_type == r_match_payload_type);
    assign seq_diff = r_in.rtp_seq - r_last_seq;
    assign newer    = (seq_diff != 16'd0) && !seq_diff[15];

    always_comb begin
        n_out_value  = '0;
        n_last_seq   = r_last_seq;
        n_seq_primed = r_seq_primed;
        n_last_stamp = r_last_stamp;
        case (r_feature_kind)
            FK_IP_PKTS:     n_out_value = {15'd0, r_in.is_ip};
            FK_IP_SRC_PKTS: n_out_value = {15'd0,
                                r_in.is_ip && (r_in.src_addr == r_match_src_addr)};
            FK_IP_BYTES:    n_out_value = r_in.is_ip ? r_in.ip_total_len : 16'd0;
            FK_TCP_PKTS:    n_out_value = {15'd0, r_in.is_tcp && port_ok};
            FK_TCP_BYTES:   n_out_value = (r_in.is_tcp && port_ok) ? r_in.ip_total_len : 16'd0;
            FK_UDP_PKTS:    n_out_value = {15'd0, r_in.is_udp && port_ok};
            FK_UDP_BYTES:   n_out_value = (r_in.is_udp && port_ok) ? r_in.ip_total_len : 16'd0;
            FK_RTP_PKTS:    n_out_value = {15'd0, rtp_ok};
            FK_RTP_BYTES:   n_out_value = rtp_ok ? r_in.ip_total_len : 16'd0;
            FK_LOST_PKTS, FK_LOST_FRAMES: begin
                if (rtp_ok) begin
                    if (!r_seq_primed) begin
                        n_last_seq   = r_in.rtp_seq;
                        n_seq_primed = 1'b1;
                    end else if (newer) begin
                        n_last_seq = r_in.rtp_seq;
                        if (r_feature_kind == FK_LOST_PKTS) begin
                            n_out_value = seq_diff - 16'd1;
                        end else begin
                            n_out_value  = {15'd0, (seq_diff > 16'd1) &&
                                                   (r_in.rtp_stamp != r_last_stamp)};
                            n_last_stamp = r_in.rtp_stamp;
                        end
                    end
                end
            end
            default: n_out_value = '0;
        endcase
    end

    // Sequence state, updated as a request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq   <= '0;
            r_seq_primed <= 1'b0;
            r_last_stamp <= '0;
        end else if (proc) begin
            r_last_seq   <= n_last_seq;
            r_seq_primed <= n_seq_primed;
            r_last_stamp <= n_last_stamp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_feat.valid              = r_out_valid;
    assign o_feat.data.feature_value = r_out_value;

    `RTLM_ASSERT_NXT(a_in_held, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid,
        "pending request dropped while result stalled")
    `RTLM_ASSERT_NXT(a_state_idle, i_clk, i_rst_n, !proc,
        $stable(r_last_seq) && $stable(r_last_stamp) && $stable(r_seq_primed),
        "sequence state changed without a request")
    `RTLM_ASSERT_NXT(a_primed_sticky, i_clk, i_rst_n, r_seq_primed, r_seq_primed,
        "sequence tracking lost its primed state")
    `RTLM_ASSERT_NXT(a_frame_flag, i_clk, i_rst_n,
        proc && (r_feature_kind == FK_LOST_FRAMES), r_out_value <= 16'd1,
        "lost-frame result above one")
    `RTLM_ASSERT_IMP(a_stamp_with_seq, i_clk, i_rst_n,
        proc && (n_last_stamp != r_last_stamp), n_last_seq != r_last_seq,
        "timestamp updated without a newer sequence number")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the RTP traffic loss monitor: random and directed packet requests.
module testbench;
    import rtlm_pkg::*;

    localparam logic [3:0]  FK_UNUSED   = 4'd15;
    localparam logic [1:0]  PF_UNUSED   = 2'd3;
    localparam logic [15:0] SEQ_HALF    = 16'h8000;
    localparam int          STALL_LIMIT = 1000;
    localparam int          REPORT_MAX  = 10;

    class feature_scoreboard;
        logic [3:0]  feature_kind;
        logic [1:0]  port_filter;
        logic [15:0] match_port;
        logic [6:0]  match_ptype;
        logic [31:0] match_addr;
        logic [15:0] last_seq;
        logic        seq_primed;
        logic [31:0] last_stamp;
        logic [15:0] expected_values[$];
        int          requests;
        int          results;
        int          nonzero;
        int          mismatches;

        function new();
            feature_kind = '0;
            port_filter  = '0;
            match_port   = '0;
            match_ptype  = '0;
            match_addr   = '0;
            last_seq     = '0;
            seq_primed   = 1'b0;
            last_stamp   = '0;
            requests     = 0;
            results      = 0;
            nonzero      = 0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FEATURE_KIND:       feature_kind = data[3:0];
                CFG_PORT_FILTER:        port_filter  = data[1:0];
                CFG_MATCH_PORT:         match_port   = data[15:0];
                CFG_MATCH_PAYLOAD_TYPE: match_ptype  = data[6:0];
                CFG_MATCH_SRC_ADDR:     match_addr   = data[31:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] predict_feature(t_pkt p);
            logic        port_pass;
            logic        rtp_pass;
            logic [15:0] gap;
            logic [15:0] value;
            port_pass = (port_filter == PF_SRC_PORT) ? (p.src_port == match_port) :
                        (port_filter == PF_DST_PORT) ? (p.dst_port == match_port) : 1'b1;
            rtp_pass  = (p.is_tcp || p.is_udp) && port_pass && (p.rtp_type == match_ptype);
            value = '0;
            case (feature_kind)
                FK_IP_PKTS:     value = {15'd0, p.is_ip};
                FK_IP_SRC_PKTS: value = {15'd0, p.is_ip && (p.src_addr == match_addr)};
                FK_IP_BYTES:    value = p.is_ip ? p.ip_total_len : 16'd0;
                FK_TCP_PKTS:    value = {15'd0, p.is_tcp && port_pass};
                FK_TCP_BYTES:   value = (p.is_tcp && port_pass) ? p.ip_total_len : 16'd0;
                FK_UDP_PKTS:    value = {15'd0, p.is_udp && port_pass};
                FK_UDP_BYTES:   value = (p.is_udp && port_pass) ? p.ip_total_len : 16'd0;
                FK_RTP_PKTS:    value = {15'd0, rtp_pass};
                FK_RTP_BYTES:   value = rtp_pass ? p.ip_total_len : 16'd0;
                FK_LOST_PKTS, FK_LOST_FRAMES: begin
                    if (rtp_pass && !seq_primed) begin
                        last_seq   = p.rtp_seq;
                        seq_primed = 1'b1;
                    end else if (rtp_pass) begin
                        gap = p.rtp_seq - last_seq;
                        if (gap != 16'd0 && gap < SEQ_HALF) begin
                            last_seq = p.rtp_seq;
                            if (feature_kind == FK_LOST_PKTS) begin
                                value = gap - 16'd1;
                            end else begin
                                value = {15'd0, (gap > 16'd1) && (p.rtp_stamp != last_stamp)};
                                last_stamp = p.rtp_stamp;
                            end
                        end
                    end
                end
                default: ;
            endcase
            return value;
        endfunction

        function void note_request(t_pkt p);
            requests++;
            expected_values.push_back(predict_feature(p));
        endfunction

        function void check_result(t_feat r);
            logic [15:0] want;
            results++;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: feature_value %0d arrived with no request outstanding",
                             r.feature_value);
                return;
            end
            want = expected_values.pop_front();
            if (r.feature_value !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result %0d: feature_value expected %0d, got %0d",
                             results, want, r.feature_value);
            end else if (want != 16'd0) begin
                nonzero++;
            end
        endfunction

        function int pending_count();
            return expected_values.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rtlm_pkt_if  pkt_if();
    rtlm_feat_if feat_if();

    rtp_traffic_loss_monitor uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pkt      (pkt_if),
        .o_feat     (feat_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    feature_scoreboard sb;

    int          src_idle_pct;
    int          snk_idle_pct;
    int          stall_cycles;
    int          settings_applied;
    logic [1:0]  cur_pf;
    logic [15:0] cur_port;
    logic [6:0]  cur_ptype;
    logic [31:0] cur_addr;
    logic [15:0] seq_cursor;
    logic [31:0] stamp_cursor;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_pkt random_packet();
        t_pkt p;
        p.is_ip        = 1'($urandom_range(1));
        p.is_tcp       = 1'($urandom_range(1));
        p.is_udp       = 1'($urandom_range(1));
        p.src_addr     = $urandom();
        p.ip_total_len = 16'($urandom());
        p.src_port     = 16'($urandom());
        p.dst_port     = 16'($urandom());
        p.rtp_type     = 7'($urandom());
        p.rtp_seq      = 16'($urandom());
        p.rtp_stamp    = $urandom();
        return p;
    endfunction

    function automatic t_pkt rtp_like(logic [15:0] seq, logic [31:0] stamp);
        t_pkt p;
        p = random_packet();
        p.is_ip     = 1'b1;
        p.is_tcp    = 1'b0;
        p.is_udp    = 1'b1;
        p.src_port  = cur_port;
        p.dst_port  = cur_port;
        p.rtp_type  = cur_ptype;
        p.rtp_seq   = seq;
        p.rtp_stamp = stamp;
        return p;
    endfunction

    // mostly requests that pass the current filters, with a moving sequence number
    function automatic t_pkt shaped_packet();
        t_pkt        p;
        int unsigned pick;
        logic [15:0] step;
        p = random_packet();
        if ($urandom_range(99) < 25) return p;
        p.is_ip  = 1'b1;
        pick     = $urandom_range(2);
        p.is_tcp = (pick != 1);
        p.is_udp = (pick != 0);
        if (cur_pf == PF_SRC_PORT) p.src_port = cur_port;
        if (cur_pf == PF_DST_PORT) p.dst_port = cur_port;
        if ($urandom_range(1)) p.src_addr = cur_addr;
        p.rtp_type = cur_ptype;
        pick = $urandom_range(99);
        if (pick < 60)      step = 16'($urandom_range(3, 1));
        else if (pick < 75) step = 16'($urandom_range(40, 4));
        else if (pick < 82) step = 16'd0;
        else if (pick < 90) step = 16'($urandom_range(32767, 41));
        else if (pick < 95) step = $urandom_range(1) ? 16'd32767 : 16'd32768;
        else                step = 16'($urandom_range(65535, 32769));
        p.rtp_seq = seq_cursor + step;
        if (step < SEQ_HALF) seq_cursor = p.rtp_seq;
        if ($urandom_range(99) < 40) p.rtp_stamp = stamp_cursor;
        stamp_cursor = p.rtp_stamp;
        return p;
    endfunction

    task automatic send_packet(t_pkt p);
        while ($urandom_range(99) < src_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.data  <= p;
        do @(posedge clk); while (!pkt_if.ready);
        sb.note_request(p);
    endtask

    task automatic drain();
        pkt_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
    endtask

    task automatic apply_config(logic [3:0] kind, logic [1:0] pf, logic [15:0] port,
                                logic [6:0] ptype, logic [31:0] addr);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] values [5];
        regs   = '{CFG_FEATURE_KIND, CFG_PORT_FILTER, CFG_MATCH_PORT,
                   CFG_MATCH_PAYLOAD_TYPE, CFG_MATCH_SRC_ADDR};
        values = '{CFG_DATA_W'(kind), CFG_DATA_W'(pf), CFG_DATA_W'(port),
                   CFG_DATA_W'(ptype), CFG_DATA_W'(addr)};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= values[i];
            @(posedge clk);
            sb.set_register(regs[i], values[i]);
        end
        cfg_we    <= 1'b0;
        cur_pf    = pf;
        cur_port  = port;
        cur_ptype = ptype;
        cur_addr  = addr;
        settings_applied++;
    endtask

    // result side: random backpressure, checking and the no-progress counter
    initial begin
        feat_if.ready <= 1'b0;
        stall_cycles = 0;
        forever begin
            @(posedge clk);
            if ((pkt_if.valid && pkt_if.ready) || (feat_if.valid && feat_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (rst_n && feat_if.valid && feat_if.ready) sb.check_result(feat_if.data);
            feat_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_pkt        pkt;
        logic [3:0]  kind;
        logic [1:0]  pf;
        logic [15:0] port;
        logic [6:0]  ptype;
        logic [31:0] addr;
        int          count;

        sb = new();
        src_idle_pct     = 36;
        snk_idle_pct     = 61;
        settings_applied = 0;
        seq_cursor       = 16'd9;
        stamp_cursor     = 32'd9;
        cur_pf = '0; cur_port = '0; cur_ptype = '0; cur_addr = '0;
        rst_n        <= 1'b0;
        pkt_if.valid <= 1'b0;
        pkt_if.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and each filter
        apply_config(FK_IP_PKTS, PF_NONE, 16'd0, 7'd0, 32'd0);
        send_packet('0);
        send_packet('1);
        drain();
        apply_config(FK_IP_SRC_PKTS, PF_NONE, 16'd0, 7'd0, 32'hFFFF_FFFF);
        send_packet('1);
        pkt = '1;
        pkt.src_addr = '0;
        send_packet(pkt);
        drain();
        apply_config(FK_IP_BYTES, PF_NONE, 16'hFFFF, 7'd127, 32'd0);
        send_packet('1);
        send_packet('0);
        drain();
        apply_config(FK_TCP_BYTES, PF_SRC_PORT, 16'hFFFF, 7'd0, 32'd0);
        send_packet('1);
        pkt = '1;
        pkt.src_port = '0;
        send_packet(pkt);
        drain();
        apply_config(FK_UDP_PKTS, PF_DST_PORT, 16'd0, 7'd0, 32'd0);
        pkt = '0;
        pkt.is_udp = 1'b1;
        send_packet(pkt);
        drain();

        // sequence tracking: priming, duplicate, widest gap, half-range old, wrap
        apply_config(FK_LOST_PKTS, PF_SRC_PORT, 16'hFFFF, 7'd127, 32'd0);
        send_packet(rtp_like(16'd100, 32'd5));
        send_packet(rtp_like(16'd100, 32'd5));
        send_packet(rtp_like(16'd101, 32'd5));
        send_packet(rtp_like(16'd32868, 32'd5));
        send_packet(rtp_like(16'd100, 32'd5));
        pkt = rtp_like(16'd32870, 32'd5);
        pkt.rtp_type = '0;
        send_packet(pkt);
        pkt = rtp_like(16'd32870, 32'd5);
        pkt.is_tcp = 1'b0;
        pkt.is_udp = 1'b0;
        send_packet(pkt);
        pkt = rtp_like(16'd32870, 32'd5);
        pkt.src_port = '0;
        send_packet(pkt);
        send_packet(rtp_like(16'hFFFF, 32'd5));
        send_packet(rtp_like(16'd2, 32'd5));
        drain();

        // lost frames share the sequence state
        apply_config(FK_LOST_FRAMES, PF_SRC_PORT, 16'hFFFF, 7'd127, 32'd0);
        send_packet(rtp_like(16'd5, 32'd0));
        send_packet(rtp_like(16'd8, 32'd7));
        send_packet(rtp_like(16'd9, 32'd9));
        drain();
        apply_config(FK_UNUSED, PF_UNUSED, 16'hFFFF, 7'd127, 32'hFFFF_FFFF);
        send_packet('1);
        drain();

        // random phases under three pacing modes
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 61 : 0;
            snk_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 36 : 0;
            for (int seg = 0; seg < 9; seg++) begin
                if ($urandom_range(99) < 45)
                    kind = $urandom_range(1) ? FK_LOST_FRAMES : FK_LOST_PKTS;
                else
                    kind = 4'($urandom_range(15));
                pf    = 2'($urandom_range(3));
                port  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                                 : 16'($urandom());
                ptype = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 7'h7F : 7'h0)
                                                 : 7'($urandom());
                addr  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0)
                                                 : $urandom();
                apply_config(kind, pf, port, ptype, addr);
                count = 50 + $urandom_range(20);
                repeat (count) send_packet(shaped_packet());
                drain();
            end
        end

        repeat (4) @(posedge clk);
        if (sb.pending_count() != 0)
            $display("ERROR: %0d feature values never arrived", sb.pending_count());
        $display("Covered %0d packet requests under %0d register settings, three pacing modes.",
                 sb.requests, settings_applied);
        $display("Checked %0d feature values (%0d nonzero), %0d mismatches.",
                 sb.results, sb.nonzero, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/rtlm_pkg.sv
src/rtlm_if.sv
src/rtp_traffic_loss_monitor.sv
tb/testbench.sv
